// File: rtl/core/segment_intersection_macros.svh
// assertion macros used by the segment intersection checker
`ifndef SEGMENT_INTERSECTION_MACROS_SVH
`define SEGMENT_INTERSECTION_MACROS_SVH

// clocked assertion, switched off while reset is held
`define SI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define SI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/si_pkg.sv
// types and constants of the segment intersection block
package si_pkg;

  localparam int COORD_BITS = 16;
  // register stages: differences, products, cross terms, range check,
  // partial products, product sum, one per quotient bit, output
  localparam int NUM_STAGES = 7 + COORD_BITS;
  // clock edges from the accepting edge to the edge that takes the result
  localparam int RESULT_DELAY = NUM_STAGES;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] seg_a_start_x;
    logic signed [COORD_BITS-1:0] seg_a_start_y;
    logic signed [COORD_BITS-1:0] seg_a_end_x;
    logic signed [COORD_BITS-1:0] seg_a_end_y;
    logic signed [COORD_BITS-1:0] seg_b_start_x;
    logic signed [COORD_BITS-1:0] seg_b_start_y;
    logic signed [COORD_BITS-1:0] seg_b_end_x;
    logic signed [COORD_BITS-1:0] seg_b_end_y;
  } seg_req_t;

  typedef struct packed {
    logic                         hit;
    logic signed [COORD_BITS-1:0] cross_x;
    logic signed [COORD_BITS-1:0] cross_y;
  } seg_res_t;

endpackage

// File: rtl/core/segment_intersection.sv
// segment intersection pipeline: crossing test and crossing point of two 2D segments
//
// input transaction: req_i is taken at a rising edge where start is high and
//   busy is low; busy is always low, so a new segment pair may enter each cycle
// output transaction: res_o is shown for exactly one cycle with res_valid_o high
// throughput: one transaction per cycle, set by the fully pipelined datapath:
//   differences, six 17x17 products, cross terms, sign normalize and range
//   check, split partial products, product sum, then one restoring-division
//   stage per quotient bit for each axis, then the final add
// hit needs a nonzero denominator and both parameters in [0,1]; the test uses
//   sign-aware compares of the numerators against the denominator, no divide
// on a hit the point is A start + trunc(tnum * span / den) per axis; on a miss
//   both coordinates are zero
// reset clears only the valid bits; transactions in flight are dropped
// the receiver cannot stall, so the pipeline advances every cycle
module segment_intersection (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  si_pkg::seg_req_t req_i,
  output logic             res_valid_o,
  output si_pkg::seg_res_t res_o
);

  localparam int CB = si_pkg::COORD_BITS;
  localparam int W  = 2 * CB + 2;  // signed cross terms
  localparam int DW = 2 * CB + 1;  // magnitude of denominator and numerator
  localparam int RW = 3 * CB + 1;  // magnitude of tnum * span
  localparam int QB = CB;          // quotient bits
  localparam int NS = si_pkg::NUM_STAGES;

  typedef struct packed {
    logic                 hit;
    logic [DW-1:0]        den;
    logic                 neg_x;
    logic                 neg_y;
    logic signed [CB-1:0] ax0;
    logic signed [CB-1:0] ay0;
  } div_ctx_t;

  // never stalls
  assign busy = 1'b0;

  // valid bits travel with the data
  logic [NS-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NS-2:0], start & ~busy};
    end
  end

  // stage 1: edge vectors and start offset
  logic signed [CB:0] s1x_d, s1y_d, s2x_d, s2y_d, dx_d, dy_d;
  logic signed [CB:0] s1x_q, s1y_q, s2x_q, s2y_q, dx_q, dy_q;
  logic signed [CB-1:0] ax0_1_q, ay0_1_q;

  assign s1x_d = $signed({req_i.seg_a_end_x[CB-1], req_i.seg_a_end_x})
               - $signed({req_i.seg_a_start_x[CB-1], req_i.seg_a_start_x});
  assign s1y_d = $signed({req_i.seg_a_end_y[CB-1], req_i.seg_a_end_y})
               - $signed({req_i.seg_a_start_y[CB-1], req_i.seg_a_start_y});
  assign s2x_d = $signed({req_i.seg_b_end_x[CB-1], req_i.seg_b_end_x})
               - $signed({req_i.seg_b_start_x[CB-1], req_i.seg_b_start_x});
  assign s2y_d = $signed({req_i.seg_b_end_y[CB-1], req_i.seg_b_end_y})
               - $signed({req_i.seg_b_start_y[CB-1], req_i.seg_b_start_y});
  assign dx_d  = $signed({req_i.seg_a_start_x[CB-1], req_i.seg_a_start_x})
               - $signed({req_i.seg_b_start_x[CB-1], req_i.seg_b_start_x});
  assign dy_d  = $signed({req_i.seg_a_start_y[CB-1], req_i.seg_a_start_y})
               - $signed({req_i.seg_b_start_y[CB-1], req_i.seg_b_start_y});

  always_ff @(posedge clk_i) begin
    s1x_q   <= s1x_d;
    s1y_q   <= s1y_d;
    s2x_q   <= s2x_d;
    s2y_q   <= s2y_d;
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    ax0_1_q <= req_i.seg_a_start_x;
    ay0_1_q <= req_i.seg_a_start_y;
  end

  // stage 2: the six cross products
  logic signed [2*CB+1:0] pa_q, pb_q, pc_q, pd_q, pe_q, pf_q;
  logic signed [CB:0]     s1x_2_q, s1y_2_q;
  logic signed [CB-1:0]   ax0_2_q, ay0_2_q;

  always_ff @(posedge clk_i) begin
    pa_q    <= s1x_q * s2y_q;
    pb_q    <= s2x_q * s1y_q;
    pc_q    <= s1x_q * dy_q;
    pd_q    <= s1y_q * dx_q;
    pe_q    <= s2x_q * dy_q;
    pf_q    <= s2y_q * dx_q;
    s1x_2_q <= s1x_q;
    s1y_2_q <= s1y_q;
    ax0_2_q <= ax0_1_q;
    ay0_2_q <= ay0_1_q;
  end

  // stage 3: denominator and numerators
  logic signed [W-1:0]  den_q, snum_q, tnum_q;
  logic signed [CB:0]   s1x_3_q, s1y_3_q;
  logic signed [CB-1:0] ax0_3_q, ay0_3_q;

  always_ff @(posedge clk_i) begin
    den_q   <= pa_q - pb_q;
    snum_q  <= pc_q - pd_q;
    tnum_q  <= pe_q - pf_q;
    s1x_3_q <= s1x_2_q;
    s1y_3_q <= s1y_2_q;
    ax0_3_q <= ax0_2_q;
    ay0_3_q <= ay0_2_q;
  end

  // stage 4: make the denominator positive, then the range check
  logic signed [W-1:0] den_abs, snum_n, tnum_n;
  logic                hit_d;
  logic [CB:0]         magx_full, magy_full;

  always_comb begin
    if (den_q[W-1]) begin
      den_abs = -den_q;
      snum_n  = -snum_q;
      tnum_n  = -tnum_q;
    end else begin
      den_abs = den_q;
      snum_n  = snum_q;
      tnum_n  = tnum_q;
    end
    hit_d = (den_q != '0) && !snum_n[W-1] && !tnum_n[W-1]
            && (snum_n <= den_abs) && (tnum_n <= den_abs);
    magx_full = s1x_3_q[CB] ? -s1x_3_q : s1x_3_q;
    magy_full = s1y_3_q[CB] ? -s1y_3_q : s1y_3_q;
  end

  logic                 hit_4_q, negx_4_q, negy_4_q;
  logic [DW-1:0]        den_4_q, tnum_4_q;
  logic [CB-1:0]        magx_4_q, magy_4_q;
  logic signed [CB-1:0] ax0_4_q, ay0_4_q;

  always_ff @(posedge clk_i) begin
    hit_4_q  <= hit_d;
    den_4_q  <= den_abs[DW-1:0];
    tnum_4_q <= tnum_n[DW-1:0];
    magx_4_q <= magx_full[CB-1:0];
    magy_4_q <= magy_full[CB-1:0];
    negx_4_q <= s1x_3_q[CB];
    negy_4_q <= s1y_3_q[CB];
    ax0_4_q  <= ax0_3_q;
    ay0_4_q  <= ay0_3_q;
  end

  // stage 5: tnum * |span| as two partial products per axis
  logic [2*CB-1:0] plo_x_q, plo_y_q;
  logic [2*CB:0]   phi_x_q, phi_y_q;
  div_ctx_t        ctx_5_q;

  always_ff @(posedge clk_i) begin
    plo_x_q <= tnum_4_q[CB-1:0] * magx_4_q;
    plo_y_q <= tnum_4_q[CB-1:0] * magy_4_q;
    phi_x_q <= tnum_4_q[DW-1:CB] * magx_4_q;
    phi_y_q <= tnum_4_q[DW-1:CB] * magy_4_q;
    ctx_5_q <= '{hit: hit_4_q, den: den_4_q, neg_x: negx_4_q, neg_y: negy_4_q,
                 ax0: ax0_4_q, ay0: ay0_4_q};
  end

  // stage 6: sum of partial products, first divider input
  logic [RW-1:0] rem_x_q [QB+1];
  logic [RW-1:0] rem_y_q [QB+1];
  logic [QB-1:0] quo_x_q [QB+1];
  logic [QB-1:0] quo_y_q [QB+1];
  div_ctx_t      ctx_q   [QB+1];

  always_ff @(posedge clk_i) begin
    rem_x_q[0] <= (RW'(phi_x_q) << CB) + RW'(plo_x_q);
    rem_y_q[0] <= (RW'(phi_y_q) << CB) + RW'(plo_y_q);
    quo_x_q[0] <= '0;
    quo_y_q[0] <= '0;
    ctx_q[0]   <= ctx_5_q;
  end

  // restoring division, one quotient bit per stage, most significant first
  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int Sh = QB - 1 - k;
    logic [RW:0]   trial_x, trial_y;
    logic [RW-1:0] den_sh;

    assign den_sh  = RW'(ctx_q[k].den) << Sh;
    assign trial_x = {1'b0, rem_x_q[k]} - {1'b0, den_sh};
    assign trial_y = {1'b0, rem_y_q[k]} - {1'b0, den_sh};

    always_ff @(posedge clk_i) begin
      rem_x_q[k+1] <= trial_x[RW] ? rem_x_q[k] : trial_x[RW-1:0];
      rem_y_q[k+1] <= trial_y[RW] ? rem_y_q[k] : trial_y[RW-1:0];
      quo_x_q[k+1] <= quo_x_q[k] | (QB'(!trial_x[RW]) << Sh);
      quo_y_q[k+1] <= quo_y_q[k] | (QB'(!trial_y[RW]) << Sh);
      ctx_q[k+1]   <= ctx_q[k];
    end
  end

  // output stage: apply the span sign and add the start point
  logic [CB:0]      qs_x, qs_y;
  si_pkg::seg_res_t res_d, res_q;
  div_ctx_t         ctx_f;

  always_comb begin
    ctx_f = ctx_q[QB];
    qs_x  = ctx_f.neg_x ? -{1'b0, quo_x_q[QB]} : {1'b0, quo_x_q[QB]};
    qs_y  = ctx_f.neg_y ? -{1'b0, quo_y_q[QB]} : {1'b0, quo_y_q[QB]};
    res_d.hit = ctx_f.hit;
    if (ctx_f.hit) begin
      res_d.cross_x = ctx_f.ax0 + $signed(qs_x[CB-1:0]);
      res_d.cross_y = ctx_f.ay0 + $signed(qs_y[CB-1:0]);
    end else begin
      res_d.cross_x = '0;
      res_d.cross_y = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = vld_q[NS-1];
  assign res_o       = res_q;

endmodule

// File: rtl/core/si_checker.sv
// port-level checks for the segment intersection pipeline
`include "segment_intersection_macros.svh"

module si_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             res_valid_o,
  input si_pkg::seg_res_t res_o
);

  `SI_ASSERT_ALWAYS(a_never_busy, clk_i, !busy, "busy raised")
  `SI_ASSERT(a_result_follows, clk_i, rst_ni, start |-> ##(si_pkg::RESULT_DELAY) res_valid_o, "transaction lost")
  `SI_ASSERT(a_no_invented, clk_i, rst_ni, res_valid_o |-> $past(start, si_pkg::RESULT_DELAY), "result without transaction")
  `SI_ASSERT(a_miss_zero, clk_i, rst_ni, (res_valid_o && !res_o.hit) |-> (res_o.cross_x == '0 && res_o.cross_y == '0), "miss with nonzero point")

endmodule

bind segment_intersection si_checker u_si_checker (.*);
